// ===== src/u8cp_pkg.sv =====
// shared types, constants and lead byte classification for the utf-8 decoder
package u8cp_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [CP_W-1:0] MIN_CP4    = 21'h010000;
	localparam logic [CP_W-1:0] MIN_CP3    = 21'h000800;
	localparam logic [CP_W-1:0] MIN_CP2    = 21'h000080;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_1   = 3'd1;
	localparam logic [2:0] LEN_2   = 3'd2;
	localparam logic [2:0] LEN_3   = 3'd3;
	localparam logic [2:0] LEN_4   = 3'd4;

	// one entry per input byte that releases results
	typedef struct packed {
		logic [2:0]      count;
		logic [CP_W-1:0] last_cp;
		logic            last_repl;
		logic            eot;
	} run_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		len = LEN_BAD;
		if (lead[7] == 1'b0) begin
			len = LEN_1;
		end else if (lead[7:5] == 3'b110) begin
			len = LEN_2;
		end else if (lead[7:4] == 4'b1110) begin
			len = LEN_3;
		end else if (lead[7:3] == 5'b11110) begin
			len = LEN_4;
		end
		return len;
	endfunction

endpackage

// ===== src/u8cp_front.sv =====
// front end: takes bytes, tracks the pending sequence and pushes one run per byte that releases results
module u8cp_front import u8cp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_eot,
	input  logic       in_fire,
	output logic       push,
	output run_t       push_run
);

	logic [1:0]      cnt_q;
	logic [1:0]      cnt_d;
	logic [7:0]      pend_q [3];
	logic            wr_en;
	logic [1:0]      wr_idx;
	logic [2:0]      len_b;
	logic [2:0]      need;
	logic            is_cont;
	logic            f_ascii;
	logic            f_bad;
	logic [2:0]      cnt_ext;
	logic [CP_W-1:0] v2;
	logic [CP_W-1:0] v3;
	logic [CP_W-1:0] v4;
	logic [CP_W-1:0] full_cp;
	logic            full_ok;
	run_t            run;

	always_comb begin
		len_b   = seq_len(in_byte);
		need    = seq_len(pend_q[0]);
		is_cont = (in_byte[7:6] == 2'b10);
		f_ascii = (len_b == LEN_1);
		f_bad   = (len_b == LEN_BAD) || in_eot;
		cnt_ext = {1'b0, cnt_q};

		v2 = {10'd0, pend_q[0][4:0], in_byte[5:0]};
		v3 = {5'd0, pend_q[0][3:0], pend_q[1][5:0], in_byte[5:0]};
		v4 = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], in_byte[5:0]};
		case (need)
			LEN_2: begin
				full_cp = v2;
				full_ok = (v2 >= MIN_CP2);
			end
			LEN_3: begin
				full_cp = v3;
				full_ok = (v3 >= MIN_CP3) && !((v3 >= SURR_LO) && (v3 <= SURR_HI));
			end
			LEN_4: begin
				full_cp = v4;
				full_ok = (v4 >= MIN_CP4) && (v4 <= MAX_SCALAR);
			end
			default: begin
				full_cp = REPL_CP;
				full_ok = 1'b0;
			end
		endcase

		run.count     = 3'd0;
		run.last_cp   = REPL_CP;
		run.last_repl = 1'b1;
		run.eot       = in_eot;
		cnt_d         = cnt_q;
		wr_en         = 1'b0;
		wr_idx        = cnt_q;

		if (cnt_q == 2'd0) begin
			if (f_ascii) begin
				run.count     = 3'd1;
				run.last_cp   = {13'd0, in_byte};
				run.last_repl = 1'b0;
			end else if (f_bad) begin
				run.count = 3'd1;
			end else begin
				wr_en  = 1'b1;
				wr_idx = 2'd0;
				cnt_d  = 2'd1;
			end
		end else if (is_cont) begin
			if (cnt_ext + 3'd1 == need) begin
				if (full_ok) begin
					run.count     = 3'd1;
					run.last_cp   = full_cp;
					run.last_repl = 1'b0;
				end else begin
					run.count = cnt_ext + 3'd1;
				end
				cnt_d = 2'd0;
			end else if (in_eot || (cnt_ext + 3'd1 > need) || (cnt_q == 2'd3)) begin
				run.count = cnt_ext + 3'd1;
				cnt_d     = 2'd0;
			end else begin
				wr_en = 1'b1;
				cnt_d = cnt_q + 2'd1;
			end
		end else begin
			cnt_d = 2'd0;
			if (f_ascii) begin
				run.count     = cnt_ext + 3'd1;
				run.last_cp   = {13'd0, in_byte};
				run.last_repl = 1'b0;
			end else if (f_bad) begin
				run.count = cnt_ext + 3'd1;
			end else begin
				run.count = cnt_ext;
				wr_en     = 1'b1;
				wr_idx    = 2'd0;
				cnt_d     = 2'd1;
			end
		end
	end

	assign push     = in_fire && (run.count != 3'd0);
	assign push_run = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && wr_en) begin
			pend_q[wr_idx] <= in_byte;
		end
	end

endmodule

// ===== src/u8cp_queue.sv =====
// small queue of runs between the front and back ends
module u8cp_queue import u8cp_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_run,
	input  logic pop,
	output logic full,
	output logic empty,
	output run_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	run_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == FullCnt);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

endmodule

// ===== src/u8cp_back.sv =====
// back end: expands each run into result beats through an output register
module u8cp_back import u8cp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  run_t            head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CP_W-1:0] out_cp,
	output logic            out_repl,
	output logic            out_last_run,
	output logic            out_done
);

	logic [1:0]      idx_q;
	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            repl_q;
	logic            last_run_q;
	logic            done_q;
	logic            load;
	logic            beat_last;

	assign load      = !empty && (!valid_q || out_ready);
	assign beat_last = ({1'b0, idx_q} + 3'd1 == head.count);
	assign pop       = load && beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= beat_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q       <= beat_last ? head.last_cp : REPL_CP;
			repl_q     <= beat_last ? head.last_repl : 1'b1;
			last_run_q <= beat_last;
			done_q     <= beat_last && head.eot;
		end
	end

	assign out_valid    = valid_q;
	assign out_cp       = cp_q;
	assign out_repl     = repl_q;
	assign out_last_run = last_run_q;
	assign out_done     = done_q;

endmodule

// ===== src/utf8_to_codepoint_decoder.sv =====
// utf-8 to code point decoder with replacement, top level
// a taken byte's results pass through the run queue and the output register
// throughput: one byte per cycle while the run queue has room
// a byte releasing n results gives n beats, one beat per cycle while not stalled
// the run queue depth sets how long the byte side runs ahead of a stalled output
// reset: asynchronous, active low; clears the pending count, queue and output valid
module utf8_to_codepoint_decoder import u8cp_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [20:0] code_point, [23:21] zero
	output logic [1:0]  m_axis_tuser,  // [0] was_replaced, [1] last_of_run
	output logic        m_axis_tlast   // text_done
);

	logic            in_fire;
	logic            push;
	run_t            push_run;
	logic            pop;
	logic            full;
	logic            empty;
	run_t            head;
	logic [CP_W-1:0] out_cp;
	logic            out_repl;
	logic            out_last_run;
	logic            out_done;

	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	u8cp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (s_axis_tdata),
		.in_eot   (s_axis_tlast),
		.in_fire  (in_fire),
		.push     (push),
		.push_run (push_run)
	);

	u8cp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	u8cp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_cp       (out_cp),
		.out_repl     (out_repl),
		.out_last_run (out_last_run),
		.out_done     (out_done)
	);

	assign m_axis_tdata = {3'b000, out_cp};
	assign m_axis_tuser = {out_last_run, out_repl};
	assign m_axis_tlast = out_done;

endmodule

// ===== src/u8cp_checker.sv =====
// port checker for the utf-8 decoder and its bind to the top level
module u8cp_checker import u8cp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	logic [CP_W-1:0] cp;
	assign cp = m_axis_tdata[CP_W-1:0];

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// end of text only on the last beat of a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("text_done without last_of_run");

	// replaced beats carry the replacement character
	a_repl_cp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> cp == REPL_CP)
		else $error("replaced beat with wrong code point");

	// decoded beats are unicode scalars
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		(cp <= MAX_SCALAR) && !((cp >= SURR_LO) && (cp <= SURR_HI)))
		else $error("decoded beat is not a scalar value");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:CP_W] == '0)
		else $error("nonzero padding in tdata");

endmodule

bind utf8_to_codepoint_decoder u8cp_checker u_chk (.*);
